### hdl/complex_integer_power_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for complex_integer_power_top
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_INTEGER_POWER_TOP_ASSERT_SVH
`define COMPLEX_INTEGER_POWER_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define CIP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define CIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hdl/cip_pkg.sv
// ----------------------------------------------------------------------------
// cip_pkg
// Widths, codes, control types and saturation for the complex power block.
// ----------------------------------------------------------------------------
package cip_pkg;

    localparam int DATA_BITS = 32;
    localparam int FRAC_BITS = 28;
    localparam int EXP_BITS  = 16;

    // Shifted product and sum widths
    localparam int PROD_W = 2 * DATA_BITS - FRAC_BITS;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CNT_W  = $clog2(EXP_BITS + 1);

    typedef logic signed [DATA_BITS-1:0] t_data;
    typedef logic signed [PROD_W-1:0]    t_prod;
    typedef logic signed [SUM_W-1:0]     t_sum;

    localparam t_data SAT_MAX  = {1'b0, {(DATA_BITS-1){1'b1}}};
    localparam t_data SAT_MIN  = {1'b1, {(DATA_BITS-1){1'b0}}};
    localparam bit    ONE_FITS = (FRAC_BITS < DATA_BITS - 1);
    localparam t_data ONE_VAL  = ONE_FITS ? (t_data'(1) << FRAC_BITS) : SAT_MAX;

    // Multiplier operand selects
    typedef enum logic {
        A_RE,
        A_IM
    } t_asel;

    typedef enum logic [1:0] {
        B_RE,
        B_IM,
        B_BR,
        B_BI
    } t_bsel;

    // Combine operation ahead of saturation
    typedef enum logic [1:0] {
        SUM_ACC_SUB_P,
        SUM_ACC_ADD_P,
        SUM_DBL_P
    } t_sumop;

    // Sequencer states
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_FIND  = 13'b0000000000010,
        S_CHECK = 13'b0000000000100,
        S_SQ0   = 13'b0000000001000,
        S_SQ1   = 13'b0000000010000,
        S_SQ2   = 13'b0000000100000,
        S_SQ3   = 13'b0000001000000,
        S_MU0   = 13'b0000010000000,
        S_MU1   = 13'b0000100000000,
        S_MU2   = 13'b0001000000000,
        S_MU3   = 13'b0010000000000,
        S_MU4   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    // Sequencer to datapath controls
    typedef struct packed {
        logic   load;
        logic   load_one;
        t_asel  a_sel;
        t_bsel  b_sel;
        logic   acc_load;
        t_sumop sum_op;
        logic   wr_re;
        logic   wr_im;
        logic   out_load;
    } t_ctl;

    typedef struct packed {
        logic  ov;
        t_data val;
    } t_sat;

    // Clamp a sum to the data range and flag when clamped
    function automatic t_sat sat(input t_sum s);
        t_sat r;
        logic [SUM_W-DATA_BITS:0] hi;
        hi = s[SUM_W-1:DATA_BITS-1];
        if ((&hi) || !(|hi)) begin
            r.ov  = 1'b0;
            r.val = s[DATA_BITS-1:0];
        end else begin
            r.ov  = 1'b1;
            r.val = s[SUM_W-1] ? SAT_MIN : SAT_MAX;
        end
        return r;
    endfunction

endpackage

### hdl/cip_mul.sv
// ----------------------------------------------------------------------------
// cip_mul
// Shared signed multiplier with fraction shift and registered product.
// ----------------------------------------------------------------------------
module cip_mul (
    input  logic           i_clk,
    input  cip_pkg::t_data i_a,
    input  cip_pkg::t_data i_b,
    output cip_pkg::t_prod o_p
);
    import cip_pkg::*;

    logic signed [2*DATA_BITS-1:0] w_full;
    logic signed [2*DATA_BITS-1:0] w_shift;
    t_prod                         r_p;

    // Full product, truncated toward minus infinity
    assign w_full  = i_a * i_b;
    assign w_shift = w_full >>> FRAC_BITS;

    // Hold product for the next step
    always_ff @(posedge i_clk) begin
        r_p <= w_shift[PROD_W-1:0];
    end

    assign o_p = r_p;

endmodule

### hdl/cip_ctrl.sv
// ----------------------------------------------------------------------------
// cip_ctrl
// Sequencer: scans the exponent and steps square and multiply operations.
// ----------------------------------------------------------------------------
module cip_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [cip_pkg::EXP_BITS-1:0]  i_exponent,
    input  logic                          i_out_free,
    output logic                          o_stall,
    output cip_pkg::t_ctl                 o_ctl
);
    import cip_pkg::*;

    t_state              r_state, n_state;
    logic [EXP_BITS-1:0] r_exp, n_exp;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                w_accept;
    logic                w_msb;

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_msb    = r_exp[EXP_BITS-1];
    assign o_stall  = (r_state != S_IDLE);

    // Next state and controls
    always_comb begin
        n_state = r_state;
        n_exp   = r_exp;
        n_cnt   = r_cnt;
        o_ctl   = '0;
        o_ctl.a_sel  = A_RE;
        o_ctl.b_sel  = B_RE;
        o_ctl.sum_op = SUM_ACC_SUB_P;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_ctl.load     = 1'b1;
                    o_ctl.load_one = (i_exponent == '0);
                    n_exp          = i_exponent;
                    n_cnt          = CNT_W'(EXP_BITS);
                    n_state        = (i_exponent == '0) ? S_DONE : S_FIND;
                end
            end
            S_FIND: begin
                n_exp = r_exp << 1;
                n_cnt = r_cnt - 1'b1;
                if (w_msb) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = (r_cnt == '0) ? S_DONE : S_SQ0;
            end
            S_SQ0: begin
                o_ctl.a_sel = A_RE;
                o_ctl.b_sel = B_RE;
                n_state     = S_SQ1;
            end
            S_SQ1: begin
                o_ctl.a_sel    = A_IM;
                o_ctl.b_sel    = B_IM;
                o_ctl.acc_load = 1'b1;
                n_state        = S_SQ2;
            end
            S_SQ2: begin
                o_ctl.a_sel  = A_RE;
                o_ctl.b_sel  = B_IM;
                o_ctl.sum_op = SUM_ACC_SUB_P;
                o_ctl.wr_re  = 1'b1;
                n_state      = S_SQ3;
            end
            S_SQ3: begin
                o_ctl.sum_op = SUM_DBL_P;
                o_ctl.wr_im  = 1'b1;
                if (w_msb) begin
                    n_state = S_MU0;
                end else begin
                    n_exp   = r_exp << 1;
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_MU0: begin
                o_ctl.a_sel = A_RE;
                o_ctl.b_sel = B_BR;
                n_state     = S_MU1;
            end
            S_MU1: begin
                o_ctl.a_sel    = A_IM;
                o_ctl.b_sel    = B_BI;
                o_ctl.acc_load = 1'b1;
                n_state        = S_MU2;
            end
            S_MU2: begin
                o_ctl.a_sel  = A_RE;
                o_ctl.b_sel  = B_BI;
                o_ctl.sum_op = SUM_ACC_SUB_P;
                o_ctl.wr_re  = 1'b1;
                n_state      = S_MU3;
            end
            S_MU3: begin
                o_ctl.a_sel    = A_IM;
                o_ctl.b_sel    = B_BR;
                o_ctl.acc_load = 1'b1;
                n_state        = S_MU4;
            end
            S_MU4: begin
                o_ctl.sum_op = SUM_ACC_ADD_P;
                o_ctl.wr_im  = 1'b1;
                n_exp        = r_exp << 1;
                n_cnt        = r_cnt - 1'b1;
                n_state      = S_CHECK;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_exp   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_exp   <= n_exp;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### hdl/complex_integer_power_top.sv
// ----------------------------------------------------------------------------
// complex_integer_power_top
// Complex fixed-point base raised to an unsigned integer power.
// ----------------------------------------------------------------------------
// One item at a time through a single shared 32x32 multiplier. From input
// transfer to result ready, the sequencer scans for the exponent's leading
// one, then for each lower bit passes a check state and the square states
// SQ0 to SQ3, plus the multiply states MU0 to MU4 when the bit is set; a zero
// exponent goes straight to the result. The input side stalls while an item
// is in progress; a finished result waits in the working registers until the
// output register is free, and a new item is taken once the result has moved
// there.
`include "complex_integer_power_top_assert.svh"

module complex_integer_power_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  cip_pkg::t_data                i_base_real,
    input  cip_pkg::t_data                i_base_imag,
    input  logic [cip_pkg::EXP_BITS-1:0]  i_exponent,
    output logic                          o_valid,
    input  logic                          i_stall,
    output cip_pkg::t_data                o_power_real,
    output cip_pkg::t_data                o_power_imag,
    output logic                          o_overflowed
);
    import cip_pkg::*;

    t_ctl  w_ctl;
    t_data r_re, r_im, r_br, r_bi;
    t_prod r_acc;
    logic  r_ov;
    t_data w_a, w_b;
    t_prod w_p;
    t_sum  w_sum;
    t_sat  w_sat;
    logic  r_out_valid;
    t_data r_out_re, r_out_im;
    logic  r_out_ov;
    logic  w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;

    cip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_exponent (i_exponent),
        .i_out_free (w_out_free),
        .o_stall    (o_stall),
        .o_ctl      (w_ctl)
    );

    // Select multiplier operands
    assign w_a = (w_ctl.a_sel == A_IM) ? r_im : r_re;

    always_comb begin
        case (w_ctl.b_sel)
            B_RE:    w_b = r_re;
            B_IM:    w_b = r_im;
            B_BR:    w_b = r_br;
            B_BI:    w_b = r_bi;
            default: w_b = r_re;
        endcase
    end

    cip_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    // Combine products ahead of saturation
    always_comb begin
        case (w_ctl.sum_op)
            SUM_ACC_SUB_P: w_sum = SUM_W'(r_acc) - SUM_W'(w_p);
            SUM_ACC_ADD_P: w_sum = SUM_W'(r_acc) + SUM_W'(w_p);
            SUM_DBL_P:     w_sum = SUM_W'(w_p) + SUM_W'(w_p);
            default:       w_sum = '0;
        endcase
    end

    assign w_sat = sat(w_sum);

    // Working value, base, accumulator and overflow flag
    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_re <= w_ctl.load_one ? ONE_VAL : i_base_real;
            r_im <= w_ctl.load_one ? '0 : i_base_imag;
            r_br <= i_base_real;
            r_bi <= i_base_imag;
            r_ov <= w_ctl.load_one && !ONE_FITS;
        end else begin
            if (w_ctl.wr_re) begin
                r_re <= w_sat.val;
            end
            if (w_ctl.wr_im) begin
                r_im <= w_sat.val;
            end
            if (w_ctl.wr_re || w_ctl.wr_im) begin
                r_ov <= r_ov || w_sat.ov;
            end
        end
        if (w_ctl.acc_load) begin
            r_acc <= w_p;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_ctl.out_load) begin
            r_out_re <= r_re;
            r_out_im <= r_im;
            r_out_ov <= r_ov;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_power_real = r_out_re;
    assign o_power_imag = r_out_im;
    assign o_overflowed = r_out_ov;

    // Checks on sequencing and result hand-off
    `CIP_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `CIP_ASSERT_SAME(a_out_load_free, i_clk, i_rst_n, w_ctl.out_load, w_out_free)
    `CIP_ASSERT_NEXT(a_ov_sticky, i_clk, i_rst_n, r_ov && !w_ctl.load && o_stall, r_ov)
    `CIP_ASSERT_SAME(a_no_load_busy, i_clk, i_rst_n, w_ctl.load, !o_stall && i_valid)

endmodule

### bench/tb_complex_integer_power_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_complex_integer_power_top
// Self-checking bench for the complex fixed-point power block. A directed
// burst of corner bases and exponents is followed by random items of several
// shapes: full-range, within the unit square, near the unit circle and edge
// values. Each input transfer is predicted in Q4.28 with truncated products
// and saturation. Every result transfer is compared in order, field by field.
// ----------------------------------------------------------------------------
import cip_pkg::*;

typedef struct packed {
    t_data re;
    t_data im;
    logic  ov;
} t_power;

// Hold expected powers in transfer order and compare results against them
class t_power_scoreboard;
    t_power awaited[$];
    bit     clamped;
    int     checked;
    int     mismatches;
    int     zero_exps;
    int     saturated;

    // Full-width product truncated toward minus infinity
    function longint scaled_mul(longint a, longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    // Clamp to the data range and remember that it happened
    function t_data clamp(longint s);
        longint top;
        top = (longint'(1) <<< (DATA_BITS - 1)) - 1;
        if (s > top) begin
            clamped = 1'b1;
            return t_data'(top);
        end
        if (s < -top - 1) begin
            clamped = 1'b1;
            return t_data'(-top - 1);
        end
        return t_data'(s);
    endfunction

    // Left-to-right square-and-multiply below the leading one bit
    function t_power raise(t_data br, t_data bi, logic [EXP_BITS-1:0] e);
        t_power r;
        longint re, im, nr, ni, d;
        int     lead;
        clamped = 1'b0;
        if (e == 0) begin
            r.re = clamp(longint'(1) <<< FRAC_BITS);
            r.im = '0;
            r.ov = clamped;
            return r;
        end
        lead = 0;
        for (int b = 0; b < EXP_BITS; b++)
            if (e[b]) lead = b;
        re = br;
        im = bi;
        for (int b = lead - 1; b >= 0; b--) begin
            nr = clamp(scaled_mul(re, re) - scaled_mul(im, im));
            d  = scaled_mul(re, im);
            ni = clamp(d + d);
            re = nr;
            im = ni;
            if (e[b]) begin
                nr = clamp(scaled_mul(re, br) - scaled_mul(im, bi));
                ni = clamp(scaled_mul(re, bi) + scaled_mul(im, br));
                re = nr;
                im = ni;
            end
        end
        r.re = t_data'(re);
        r.im = t_data'(im);
        r.ov = clamped;
        return r;
    endfunction

    function void note_input(t_data br, t_data bi, logic [EXP_BITS-1:0] e);
        awaited.push_back(raise(br, bi, e));
        if (e == 0) zero_exps++;
    endfunction

    function void check_result(t_data re, t_data im, logic ov);
        t_power want;
        if (awaited.size() == 0) begin
            $display("%0t: unexpected result re %h im %h ov %b", $time, re, im, ov);
            mismatches++;
            return;
        end
        want = awaited.pop_front();
        checked++;
        if (want.ov) saturated++;
        if (re !== want.re) begin
            $display("%0t: power_real expected %h actual %h", $time, want.re, re);
            mismatches++;
        end
        if (im !== want.im) begin
            $display("%0t: power_imag expected %h actual %h", $time, want.im, im);
            mismatches++;
        end
        if (ov !== want.ov) begin
            $display("%0t: overflowed expected %b actual %b", $time, want.ov, ov);
            mismatches++;
        end
    endfunction

    function int outstanding();
        return awaited.size();
    endfunction
endclass

module tb_complex_integer_power_top;

    localparam t_data UNIT      = t_data'(1) <<< FRAC_BITS;
    localparam int    N_RANDOM  = 1950;
    localparam int    QUIET_MAX = 4000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic                i_stall     = 1'b0;
    t_data               i_base_real = '0;
    t_data               i_base_imag = '0;
    logic [EXP_BITS-1:0] i_exponent  = '0;
    logic                o_stall;
    logic                o_valid;
    t_data               o_power_real;
    t_data               o_power_imag;
    logic                o_overflowed;

    // Drop all idling on both sides while set
    logic calm = 1'b0;
    int   quiet_cycles = 0;

    t_power_scoreboard board = new();

    complex_integer_power_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_base_real  (i_base_real),
        .i_base_imag  (i_base_imag),
        .i_exponent   (i_exponent),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_power_real (o_power_real),
        .o_power_imag (o_power_imag),
        .o_overflowed (o_overflowed)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        i_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 32);
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_power_real, o_power_imag, o_overflowed);
    end

    // Count cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_MAX) @(posedge i_clk);
        $display("%0t: no transfer for %0d cycles", $time, QUIET_MAX);
        $display("complex_integer_power_top test failed");
        $finish;
    end

    // Present one item, idling first at random, and hold it until transferred
    task automatic send_item(input t_data br, input t_data bi,
                             input logic [EXP_BITS-1:0] e);
        while (!calm && $urandom_range(0, 99) < 32) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_base_real <= br;
        i_base_imag <= bi;
        i_exponent  <= e;
        do @(posedge i_clk); while (o_stall);
        board.note_input(br, bi, e);
    endtask

    // Hold off the input side until every expected power has come back
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic t_data edge_value();
        case ($urandom_range(0, 5))
            0:       return SAT_MIN;
            1:       return SAT_MAX;
            2:       return '0;
            3:       return UNIT;
            4:       return -UNIT;
            default: return -t_data'(1);
        endcase
    endfunction

    // Value within [-1, 1]
    function automatic t_data in_unit();
        return t_data'(int'($urandom_range(0, 32'h2000_0000)) - int'(UNIT));
    endfunction

    initial begin
        t_data               br, bi, swap;
        logic [EXP_BITS-1:0] ex;
        int                  w;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero exponent, exponent of one, extremes and exact rotations
        send_item('0, '0, '0);
        send_item(UNIT, '0, '0);
        send_item(SAT_MIN, SAT_MIN, '0);
        send_item(SAT_MAX, SAT_MAX, 16'd1);
        send_item(SAT_MIN, SAT_MIN, 16'd1);
        send_item(SAT_MIN, SAT_MAX, 16'd1);
        send_item(UNIT, '0, 16'hFFFF);
        send_item('0, UNIT, 16'd2);
        send_item('0, UNIT, 16'd3);
        send_item('0, UNIT, 16'd4);
        send_item(SAT_MIN, '0, 16'd2);
        send_item(SAT_MIN, SAT_MIN, 16'd2);
        send_item(SAT_MAX, SAT_MAX, 16'hFFFF);
        send_item(SAT_MIN, SAT_MIN, 16'hFFFF);
        send_item(-UNIT, '0, 16'hFFFF);
        send_item(-UNIT, '0, 16'h8000);
        send_item(UNIT >>> 1, UNIT >>> 1, 16'd16);
        send_item('0, '0, 16'hFFFF);
        send_item(t_data'(1), -t_data'(1), 16'd7);
        send_item(UNIT + 1, '0, 16'hFFFF);
        send_item(32'sh0B50_4F33, 32'sh0B50_4F33, 16'd8);
        send_item(-t_data'(1), -t_data'(1), 16'hFFFF);
        send_item(SAT_MAX, SAT_MIN, 16'd3);
        wait_for_results();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 700) calm <= 1'b1;
            if (n == 1000) calm <= 1'b0;
            if (n % 400 == 399) wait_for_results();

            // Pick the base shape
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    br = t_data'($urandom());
                    bi = t_data'($urandom());
                end
                3, 4: begin
                    br = in_unit();
                    bi = in_unit();
                end
                9: begin
                    br = edge_value();
                    bi = edge_value();
                end
                default: begin
                    br = UNIT - t_data'($urandom_range(0, 32'h0040_0000));
                    bi = t_data'($urandom_range(0, 32'h0200_0000));
                    if ($urandom_range(0, 1)) begin
                        swap = br;
                        br   = bi;
                        bi   = swap;
                    end
                    if ($urandom_range(0, 1)) br = -br;
                    if ($urandom_range(0, 1)) bi = -bi;
                end
            endcase

            // Pick the exponent, spreading the leading one over all positions
            case ($urandom_range(0, 3))
                0:       ex = EXP_BITS'($urandom());
                1:       ex = EXP_BITS'($urandom_range(0, 20));
                default: begin
                    w  = $urandom_range(1, EXP_BITS);
                    ex = EXP_BITS'($urandom() & ((32'd1 << w) - 1));
                end
            endcase
            send_item(br, bi, ex);
        end
        i_valid <= 1'b0;

        // Drain, then watch for stray results
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("covered %0d powers: %0d with zero exponent, %0d saturated",
                 board.checked, board.zero_exps, board.saturated);
        $display("field mismatches: %0d", board.mismatches);
        if (board.mismatches == 0)
            $display("complex_integer_power_top test passed");
        else
            $display("complex_integer_power_top test failed");
        $finish;
    end

endmodule
